[rtl/core/sic_pkg.sv]
// ----------------------------------------------------------------------------
// sic_pkg
// shared types, codes and the crc-16 byte update of the settings image checker
// ----------------------------------------------------------------------------
package sic_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RS_SIZE,
    RS_ID,
    RS_PAYLOAD
  } rstep_t;

  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_MAGIC   = 3'd2;
  localparam logic [2:0] ST_SIZE    = 3'd3;
  localparam logic [2:0] ST_COUNT   = 3'd4;
  localparam logic [2:0] ST_HCRC    = 3'd5;
  localparam logic [2:0] ST_DCRC    = 3'd6;
  localparam logic [2:0] ST_ID      = 3'd7;

  localparam logic [2:0] CFG_MAGIC     = 3'd0;
  localparam logic [2:0] CFG_MAX_DATA  = 3'd1;
  localparam logic [2:0] CFG_MAX_REC   = 3'd2;
  localparam logic [2:0] CFG_USER_0    = 3'd3;
  localparam logic [2:0] CFG_USER_1    = 3'd4;
  localparam logic [2:0] CFG_USER_2    = 3'd5;
  localparam logic [2:0] CFG_USER_3    = 3'd6;

  localparam int          NUM_USERS     = 4;
  localparam logic [2:0]  NO_USER       = 3'd4;
  localparam logic [2:0]  HDR_LAST      = 3'd7;
  localparam logic [2:0]  HDR_CRC_LO    = 3'd6;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  localparam logic [7:0]  RST_MAGIC     = 8'hE5;
  localparam logic [15:0] RST_MAX_DATA  = 16'd1024;
  localparam logic [7:0]  RST_MAX_REC   = 8'd32;
  localparam logic [6:0]  RST_USER_0    = 7'h54;
  localparam logic [6:0]  RST_USER_1    = 7'h52;
  localparam logic [6:0]  RST_USER_2    = 7'h42;
  localparam logic [6:0]  RST_USER_3    = 7'h53;

  typedef struct packed {
    logic [7:0]                 magic;
    logic [15:0]                max_data_size;
    logic [7:0]                 max_records;
    logic [NUM_USERS-1:0][6:0]  user_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       in_payload;
    logic [2:0] record_user;
    logic       record_end;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] good_records;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/sic_cfg.sv]
// ----------------------------------------------------------------------------
// sic_cfg
// configuration registers of the settings image checker
// ----------------------------------------------------------------------------
module sic_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [15:0]   wr_data,
  output sic_pkg::cfg_t cfg
);

  sic_pkg::cfg_t cfg_r;
  sic_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        sic_pkg::CFG_MAGIC:    cfg_nxt.magic         = wr_data[7:0];
        sic_pkg::CFG_MAX_DATA: cfg_nxt.max_data_size = wr_data;
        sic_pkg::CFG_MAX_REC:  cfg_nxt.max_records   = wr_data[7:0];
        sic_pkg::CFG_USER_0:   cfg_nxt.user_id[0]    = wr_data[6:0];
        sic_pkg::CFG_USER_1:   cfg_nxt.user_id[1]    = wr_data[6:0];
        sic_pkg::CFG_USER_2:   cfg_nxt.user_id[2]    = wr_data[6:0];
        sic_pkg::CFG_USER_3:   cfg_nxt.user_id[3]    = wr_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic         <= sic_pkg::RST_MAGIC;
      cfg_r.max_data_size <= sic_pkg::RST_MAX_DATA;
      cfg_r.max_records   <= sic_pkg::RST_MAX_REC;
      cfg_r.user_id[0]    <= sic_pkg::RST_USER_0;
      cfg_r.user_id[1]    <= sic_pkg::RST_USER_1;
      cfg_r.user_id[2]    <= sic_pkg::RST_USER_2;
      cfg_r.user_id[3]    <= sic_pkg::RST_USER_3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/sic_engine.sv]
// ----------------------------------------------------------------------------
// sic_engine
// per-byte header parse, crc check and record walk with the image state
// ----------------------------------------------------------------------------
module sic_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic [7:0]    item_byte,
  input  logic          item_start,
  input  sic_pkg::cfg_t cfg,
  output sic_pkg::res_t res
);

  sic_pkg::phase_t phase_r, phase_nxt;
  sic_pkg::rstep_t rstep_r, rstep_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  rec_total_r, rec_total_nxt;
  logic [15:0] data_size_r, data_size_nxt;
  logic [15:0] exp_crc_r, exp_crc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  pay_left_r, pay_left_nxt;
  logic [2:0]  cur_user_r, cur_user_nxt;
  logic [7:0]  rec_seen_r, rec_seen_nxt;
  logic        id_err_r, id_err_nxt;
  logic [7:0]  rec_before_err_r, rec_before_err_nxt;
  logic        magic_bad_r, magic_bad_nxt;
  logic        hcrc_lo_bad_r, hcrc_lo_bad_nxt;

  logic [2:0]  user_hit;
  logic [15:0] crc_upd;
  logic        hcrc_bad;

  // lowest matching user wins
  always_comb begin
    user_hit = sic_pkg::NO_USER;
    for (int n = sic_pkg::NUM_USERS - 1; n >= 0; n--) begin
      if ({1'b0, cfg.user_id[n]} == item_byte) begin
        user_hit = 3'(n);
      end
    end
  end

  always_comb begin
    phase_nxt          = phase_r;
    rstep_nxt          = rstep_r;
    hdr_idx_nxt        = hdr_idx_r;
    rec_total_nxt      = rec_total_r;
    data_size_nxt      = data_size_r;
    exp_crc_nxt        = exp_crc_r;
    crc_nxt            = crc_r;
    bytes_left_nxt     = bytes_left_r;
    pay_left_nxt       = pay_left_r;
    cur_user_nxt       = cur_user_r;
    rec_seen_nxt       = rec_seen_r;
    id_err_nxt         = id_err_r;
    rec_before_err_nxt = rec_before_err_r;
    magic_bad_nxt      = magic_bad_r;
    hcrc_lo_bad_nxt    = hcrc_lo_bad_r;
    crc_upd            = 16'h0000;
    hcrc_bad           = 1'b0;

    res              = '0;
    res.byte_out     = item_byte;
    res.record_user  = sic_pkg::NO_USER;

    // restart abandons any image in flight
    if (item_start) begin
      phase_nxt          = sic_pkg::PH_HEADER;
      hdr_idx_nxt        = 3'd0;
      crc_nxt            = sic_pkg::CRC_INIT;
      rec_total_nxt      = 8'd0;
      data_size_nxt      = 16'd0;
      exp_crc_nxt        = 16'd0;
      bytes_left_nxt     = 16'd0;
      rstep_nxt          = sic_pkg::RS_SIZE;
      pay_left_nxt       = 8'd0;
      cur_user_nxt       = sic_pkg::NO_USER;
      rec_seen_nxt       = 8'd0;
      id_err_nxt         = 1'b0;
      rec_before_err_nxt = 8'd0;
      magic_bad_nxt      = 1'b0;
      hcrc_lo_bad_nxt    = 1'b0;
    end

    crc_upd = sic_pkg::crc16_byte(crc_nxt, item_byte);

    unique case (phase_nxt)
      sic_pkg::PH_HEADER: begin
        unique case (hdr_idx_nxt)
          3'd0: magic_bad_nxt = (item_byte != cfg.magic);
          3'd1: rec_total_nxt = item_byte;
          3'd2: data_size_nxt = {8'h00, item_byte};
          3'd3: data_size_nxt = {item_byte, data_size_nxt[7:0]};
          3'd4: exp_crc_nxt   = {8'h00, item_byte};
          3'd5: exp_crc_nxt   = {item_byte, exp_crc_nxt[7:0]};
          3'd6: hcrc_lo_bad_nxt = (item_byte != crc_nxt[7:0]);
          default: ;
        endcase
        if (hdr_idx_nxt < sic_pkg::HDR_CRC_LO) begin
          crc_nxt = crc_upd;
        end
        if (hdr_idx_nxt == sic_pkg::HDR_LAST) begin
          hcrc_bad = hcrc_lo_bad_nxt || (item_byte != crc_nxt[15:8]);
          if (magic_bad_nxt) begin
            res.status = sic_pkg::ST_MAGIC;
          end else if (data_size_nxt > cfg.max_data_size) begin
            res.status = sic_pkg::ST_SIZE;
          end else if (rec_total_nxt > cfg.max_records) begin
            res.status = sic_pkg::ST_COUNT;
          end else if (hcrc_bad) begin
            res.status = sic_pkg::ST_HCRC;
          end
          crc_nxt = sic_pkg::CRC_INIT;
          if (res.status != sic_pkg::ST_PENDING) begin
            res.done_res = 1'b1;
            phase_nxt    = sic_pkg::PH_DONE;
          end else if (data_size_nxt == 16'd0) begin
            // empty data region: expected crc must equal the initial value
            res.status       = (exp_crc_nxt != sic_pkg::CRC_INIT) ? sic_pkg::ST_DCRC :
                               sic_pkg::ST_OK;
            res.good_records = rec_seen_nxt;
            res.done_res     = 1'b1;
            phase_nxt        = sic_pkg::PH_DONE;
          end else begin
            bytes_left_nxt = data_size_nxt;
            phase_nxt      = sic_pkg::PH_DATA;
          end
          hdr_idx_nxt = 3'd0;
        end else begin
          hdr_idx_nxt = hdr_idx_nxt + 3'd1;
        end
      end

      sic_pkg::PH_DATA: begin
        crc_nxt = crc_upd;
        if (!id_err_nxt && (rec_seen_nxt < rec_total_nxt)) begin
          unique case (rstep_nxt)
            sic_pkg::RS_SIZE: begin
              pay_left_nxt = item_byte;
              rstep_nxt    = sic_pkg::RS_ID;
            end
            sic_pkg::RS_ID: begin
              if (item_byte[7]) begin
                id_err_nxt         = 1'b1;
                rec_before_err_nxt = rec_seen_nxt;
                rstep_nxt          = sic_pkg::RS_SIZE;
              end else begin
                cur_user_nxt    = user_hit;
                res.record_user = user_hit;
                if (pay_left_nxt == 8'd0) begin
                  res.record_end = 1'b1;
                  rec_seen_nxt   = rec_seen_nxt + 8'd1;
                  rstep_nxt      = sic_pkg::RS_SIZE;
                end else begin
                  rstep_nxt = sic_pkg::RS_PAYLOAD;
                end
              end
            end
            default: begin
              res.in_payload  = 1'b1;
              res.record_user = cur_user_nxt;
              pay_left_nxt    = pay_left_nxt - 8'd1;
              if (pay_left_nxt == 8'd0) begin
                res.record_end = 1'b1;
                rec_seen_nxt   = rec_seen_nxt + 8'd1;
                rstep_nxt      = sic_pkg::RS_SIZE;
              end
            end
          endcase
        end
        bytes_left_nxt = bytes_left_nxt - 16'd1;
        if (bytes_left_nxt == 16'd0) begin
          if (crc_nxt != exp_crc_nxt) begin
            res.status = sic_pkg::ST_DCRC;
          end else if (id_err_nxt) begin
            res.status = sic_pkg::ST_ID;
          end else begin
            res.status = sic_pkg::ST_OK;
          end
          res.good_records = id_err_nxt ? rec_before_err_nxt : rec_seen_nxt;
          res.done_res     = 1'b1;
          phase_nxt        = sic_pkg::PH_DONE;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= sic_pkg::PH_IDLE;
      rstep_r          <= sic_pkg::RS_SIZE;
      hdr_idx_r        <= 3'd0;
      rec_total_r      <= 8'd0;
      data_size_r      <= 16'd0;
      exp_crc_r        <= 16'd0;
      crc_r            <= sic_pkg::CRC_INIT;
      bytes_left_r     <= 16'd0;
      pay_left_r       <= 8'd0;
      cur_user_r       <= sic_pkg::NO_USER;
      rec_seen_r       <= 8'd0;
      id_err_r         <= 1'b0;
      rec_before_err_r <= 8'd0;
      magic_bad_r      <= 1'b0;
      hcrc_lo_bad_r    <= 1'b0;
    end else if (adv) begin
      phase_r          <= phase_nxt;
      rstep_r          <= rstep_nxt;
      hdr_idx_r        <= hdr_idx_nxt;
      rec_total_r      <= rec_total_nxt;
      data_size_r      <= data_size_nxt;
      exp_crc_r        <= exp_crc_nxt;
      crc_r            <= crc_nxt;
      bytes_left_r     <= bytes_left_nxt;
      pay_left_r       <= pay_left_nxt;
      cur_user_r       <= cur_user_nxt;
      rec_seen_r       <= rec_seen_nxt;
      id_err_r         <= id_err_nxt;
      rec_before_err_r <= rec_before_err_nxt;
      magic_bad_r      <= magic_bad_nxt;
      hcrc_lo_bad_r    <= hcrc_lo_bad_nxt;
    end
  end

endmodule

[rtl/core/settings_image_checker.sv]
// ----------------------------------------------------------------------------
// settings_image_checker
// streaming checker for a stored settings image, one byte per request
// ----------------------------------------------------------------------------
// in_ channel: one image byte per request, in_tuser marks header byte 0.
// out_ channel: one result per input byte, the byte passed through with its
//   payload flag, user index, end of record (out_tlast) and, on the byte
//   that decides it, the final status and good record count.
// cfg_ channel: register writes, always ready; write only while idle.
// path: a byte is held in the input register, then its result is registered
//   in the result register before it appears on the out_ channel.
// throughput: one byte per cycle while the output is not stalled, with a single
//   crc-16 byte update and record walk between the input and result registers.
// reset: clears the image state to idle and loads the register defaults;
//   both channel stages come up empty.
// stall: when out_tready is low the result register holds, the input
//   register still takes one more byte, and in_tready then drops.
// ----------------------------------------------------------------------------
module settings_image_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // image_byte
  input  logic        in_tuser,   // start_image
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // byte_out, done_res, status, good_records, zero fill
  output logic [3:0]  out_tuser,  // in_payload, record_user
  output logic        out_tlast,  // record_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic          in_vld_r;
  logic [7:0]    in_byte_r;
  logic          in_start_r;
  logic          out_vld_r;
  sic_pkg::res_t res_r;
  sic_pkg::res_t res;
  sic_pkg::cfg_t cfg;
  logic          adv;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  sic_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sic_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item_byte  (in_byte_r),
    .item_start (in_start_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'h0, res_r.good_records, res_r.status, res_r.done_res,
                       res_r.byte_out};
  assign out_tuser  = {res_r.record_user, res_r.in_payload};
  assign out_tlast  = res_r.record_end;

endmodule
